// File: rtl/core/ftpf_pkg.sv
`default_nettype none

package ftpf_pkg;

	// Default number of rule slots
	localparam int DEFAULT_RULE_DEPTH = 16;

	// Request kinds carried on s_tuser
	localparam logic [1:0] CMD_CLASSIFY = 2'd0;
	localparam logic [1:0] CMD_ADD      = 2'd1;
	localparam logic [1:0] CMD_REMOVE   = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

	// Protocols that are checked
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// Field mask bit positions
	localparam int M_SRCIP = 0;
	localparam int M_DSTIP = 1;
	localparam int M_PROTO = 2;
	localparam int M_SPORT = 3;
	localparam int M_DPORT = 4;

	localparam int RULE_W  = 109;
	localparam int IN_W    = 112;
	localparam int OUT_W   = 8;

	// One rule as held in the table, last field (src_ip) in the lowest bits
	typedef struct packed {
		logic [4:0]  field_mask;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [7:0]  proto;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
	} rule_t;

	// True when the rule selects at least one field and all selected fields agree
	function automatic logic rule_hits(input rule_t r, input rule_t p);
		logic hit;
		hit = (r.field_mask != 5'd0);
		if (r.field_mask[M_SRCIP] && (r.src_ip != p.src_ip))
			hit = 1'b0;
		if (r.field_mask[M_DSTIP] && (r.dst_ip != p.dst_ip))
			hit = 1'b0;
		if (r.field_mask[M_PROTO] && (r.proto != p.proto))
			hit = 1'b0;
		if (r.field_mask[M_SPORT] && (r.sport != p.sport))
			hit = 1'b0;
		if (r.field_mask[M_DPORT] && (r.dport != p.dport))
			hit = 1'b0;
		return hit;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/five_tuple_packet_filter_top.sv
`default_nettype none

// Five-tuple packet filter. Each request on the slave stream is a classify, add or
// remove (kind on s_tuser) and gives exactly one result on the master stream: drop,
// status and the rule count after the request. Rules live in one synchronous RAM of
// RULE_DEPTH entries read at one rule per cycle; slots beyond the count are never
// used, so reset only clears the count and no clearing pass is needed. An add writes
// the rule on acceptance. A classify of a TCP or UDP packet scans the slots until the
// first hit (at most the rule count); any other packet is not scanned. A remove scans
// for an equal rule and shifts the later rules down one slot (the scan and the shift
// run back to back through the one read port); with an empty table it does no scan.
// One request is worked on at a time; the next is taken once the result has moved to
// the output register.
module five_tuple_packet_filter_top #(
	parameter int RULE_DEPTH = ftpf_pkg::DEFAULT_RULE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// src_ip[31:0], dst_ip[63:32], proto[71:64], sport[87:72], dport[103:88],
	// field_mask[108:104], zero fill [111:109]
	input  wire logic [ftpf_pkg::IN_W-1:0] s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]                s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// drop[0], status[2:1], rule_count[7:3]
	output logic [ftpf_pkg::OUT_W-1:0]     m_tdata
);
	import ftpf_pkg::*;

	localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CNT_W = $clog2(RULE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	rule_t            rd_data_s1;
	rule_t            req_q;
	logic [1:0]       cmd_q;
	logic             res_drop_q;
	logic [1:0]       res_status_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	rule_t            mem [RULE_DEPTH];

	rule_t            in_rule;
	logic             s_acc;
	logic             full;
	logic             rd_issue;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] last_idx;
	logic             is_last;
	logic             hit;
	logic             equal;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	rule_t            wr_data;
	logic             out_free;

	logic [1:0]       state_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W-1:0] rd_idx_nxt;
	logic             vld_nxt;
	logic [IDX_W-1:0] idx_nxt;
	logic             drop_nxt;
	logic [1:0]       status_nxt;
	logic             m_tvalid_nxt;

	// Unpack the request
	assign in_rule  = rule_t'(s_tdata[RULE_W-1:0]);
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign full     = (cnt_q == CNT_W'(RULE_DEPTH));
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Stream one read per cycle through the held slots
	assign rd_issue = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_idx_q < cnt_q);
	assign rd_addr  = rd_idx_q[IDX_W-1:0];
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign is_last  = (idx_s1 == last_idx);

	// Compare the rule just read against the request
	assign hit   = rule_hits(rd_data_s1, req_q);
	assign equal = (rd_data_s1 == req_q);

	// Write port: append on add, move a rule down one slot during the shift
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = in_rule;
		if (s_acc && (s_tuser == CMD_ADD) && !full) begin
			wr_en = 1'b1;
		end else if ((state_q == S_SHIFT) && vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IDX_W'(1);
			wr_data = rd_data_s1;
		end
	end

	// Rule table
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
	end

	// Hold the request and load the result register
	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_q <= in_rule;
			cmd_q <= s_tuser;
		end
		if ((state_q == S_DONE) && out_free)
			m_tdata_q <= {5'(cnt_q), res_status_q, res_drop_q};
	end

	// Sequencer: work out the next state
	always_comb begin
		state_nxt    = state_q;
		cnt_nxt      = cnt_q;
		rd_idx_nxt   = rd_idx_q;
		vld_nxt      = vld_s1;
		idx_nxt      = idx_s1;
		drop_nxt     = res_drop_q;
		status_nxt   = res_status_q;
		m_tvalid_nxt = m_tvalid_q && !m_tready;
		unique case (state_q)
			S_IDLE: begin
				vld_nxt    = 1'b0;
				rd_idx_nxt = '0;
				drop_nxt   = 1'b0;
				status_nxt = STATUS_OK;
				if (s_acc) begin
					state_nxt = S_DONE;
					unique case (s_tuser)
						CMD_CLASSIFY: begin
							if (((in_rule.proto == PROTO_TCP) ||
							     (in_rule.proto == PROTO_UDP)) && (cnt_q != '0))
								state_nxt = S_SCAN;
						end
						CMD_ADD: begin
							if (full)
								status_nxt = STATUS_FULL;
							else
								cnt_nxt = cnt_q + CNT_W'(1);
						end
						CMD_REMOVE: begin
							if (cnt_q != '0)
								state_nxt = S_SCAN;
							else
								status_nxt = STATUS_NOTFOUND;
						end
						default: ;
					endcase
				end
			end
			S_SCAN, S_SHIFT: begin
				vld_nxt = rd_issue;
				idx_nxt = rd_addr;
				if (rd_issue)
					rd_idx_nxt = rd_idx_q + CNT_W'(1);
				if (vld_s1) begin
					if (state_q == S_SHIFT) begin
						// Last rule moved down: drop the top slot
						if (is_last) begin
							cnt_nxt   = cnt_q - CNT_W'(1);
							state_nxt = S_DONE;
							vld_nxt   = 1'b0;
						end
					end else if (cmd_q == CMD_CLASSIFY) begin
						if (hit) begin
							drop_nxt  = 1'b1;
							state_nxt = S_DONE;
							vld_nxt   = 1'b0;
						end else if (is_last) begin
							state_nxt = S_DONE;
							vld_nxt   = 1'b0;
						end
					end else begin
						if (equal) begin
							if (is_last) begin
								cnt_nxt   = cnt_q - CNT_W'(1);
								state_nxt = S_DONE;
								vld_nxt   = 1'b0;
							end else begin
								state_nxt = S_SHIFT;
							end
						end else if (is_last) begin
							status_nxt = STATUS_NOTFOUND;
							state_nxt  = S_DONE;
							vld_nxt    = 1'b0;
						end
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_tvalid_nxt = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			res_drop_q   <= 1'b0;
			res_status_q <= STATUS_OK;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_nxt;
			cnt_q        <= cnt_nxt;
			rd_idx_q     <= rd_idx_nxt;
			vld_s1       <= vld_nxt;
			idx_s1       <= idx_nxt;
			res_drop_q   <= drop_nxt;
			res_status_q <= status_nxt;
			m_tvalid_q   <= m_tvalid_nxt;
		end
	end

endmodule

`default_nettype wire
